// ===== hdl/stip_pkg.sv =====
// Shared types, constants and character helpers for the string to integer parser.
package stip_pkg;

    // Default sizes of the accumulator and the position counter.
    localparam int VALUE_WIDTH_DEF    = 64;
    localparam int POSITION_WIDTH_DEF = 16;

    // Fixed field widths.
    localparam int CHAR_WIDTH   = 8;
    localparam int BASE_WIDTH   = 6;
    localparam int DIGIT_WIDTH  = 6;
    localparam int OFFSET_WIDTH = 16;
    localparam int RESULT_WIDTH = 64;

    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

    // Radix codes.
    localparam logic [BASE_WIDTH-1:0] BASE_AUTO    = 6'd0;
    localparam logic [BASE_WIDTH-1:0] BASE_OCTAL   = 6'd8;
    localparam logic [BASE_WIDTH-1:0] BASE_DECIMAL = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_HEX     = 6'd16;
    localparam logic [BASE_WIDTH-1:0] BASE_RESET   = BASE_DECIMAL;

    // Marker for a character that is no digit at all.
    localparam logic [DIGIT_WIDTH-1:0] NO_DIGIT = 6'd63;

    // Character codes.
    localparam logic [CHAR_WIDTH-1:0] CHAR_TAB     = 8'd9;
    localparam logic [CHAR_WIDTH-1:0] CHAR_CR      = 8'd13;
    localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_X = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_Z = 8'h7A;

    // Parse phases; the three unused codes act like the finished phase.
    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    // Digit value of a character, NO_DIGIT when it is not 0-9, A-Z or a-z.
    function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
        logic [CHAR_WIDTH-1:0] d;
        d = {CHAR_WIDTH{1'b1}};
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            d = c - CHAR_UPPER_A + 8'd10;
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d = c - CHAR_LOWER_A + 8'd10;
        end
        return (d == {CHAR_WIDTH{1'b1}}) ? NO_DIGIT : d[DIGIT_WIDTH-1:0];
    endfunction

    // White space is tab through carriage return, and space.
    function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

endpackage

// ===== hdl/stip_if.sv =====
// Handshake channel interfaces for characters, results and the base register.

// Character channel: one character per transaction.
interface stip_char_if;
    logic                            valid;
    logic                            ready;
    logic [stip_pkg::CHAR_WIDTH-1:0] char_code;
    logic                            start_of_string;

    modport source (output valid, output char_code, output start_of_string, input ready);
    modport sink   (input valid, input char_code, input start_of_string, output ready);
endinterface

// Result channel: one converted number per transaction.
interface stip_result_if;
    logic                              valid;
    logic                              ready;
    logic [stip_pkg::RESULT_WIDTH-1:0] value;
    logic                              overflowed;
    logic                              any_digits;
    logic [stip_pkg::OFFSET_WIDTH-1:0] end_offset;

    modport source (output valid, output value, output overflowed, output any_digits,
                    output end_offset, input ready);
    modport sink   (input valid, input value, input overflowed, input any_digits,
                    input end_offset, output ready);
endinterface

// Configuration channel: writes the number base register.
interface stip_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [stip_pkg::BASE_WIDTH-1:0] number_base;

    modport source (output valid, output number_base, input ready);
    modport sink   (input valid, input number_base, output ready);
endinterface

// ===== hdl/string_to_integer_parser.sv =====
// Streaming string to unsigned integer parser, top level.
//
// Usage: characters arrive one per transaction on i_char; start_of_string marks
// the first character of a new string and clears the parse state. The parser
// skips white space, takes an optional sign and an optional 0x/0X prefix, and
// accumulates digits in the base held in the number base register (0 picks
// octal, decimal or hex from the prefix). The first non-digit, NUL included,
// produces one transaction on o_result; later characters produce nothing until
// the next start of string. The base register is written through i_cfg, which
// is always ready; the user must write it only while the parser is idle, as
// the block does not enforce this. A character is registered on acceptance and
// processed once the result slot is free; the result of its stop character is
// then registered and shown on o_result. Throughput is one character per cycle
// while the receiver does not stall; the multiply-add of the accumulator by the base is combinational.
// Reset clears the parse state and sets the base register to 10. When the
// receiver stalls with a result pending, the input register holds and i_char
// ready drops, once that register holds a character, until the result is taken.
module string_to_integer_parser #(
    parameter int VALUE_WIDTH    = stip_pkg::VALUE_WIDTH_DEF,
    parameter int POSITION_WIDTH = stip_pkg::POSITION_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    stip_char_if.sink            i_char,
    stip_cfg_if.sink             i_cfg,
    stip_result_if.source        o_result
);
    import stip_pkg::*;

    localparam int SUM_WIDTH = VALUE_WIDTH + BASE_WIDTH + 1;
    localparam int EXT_WIDTH = (POSITION_WIDTH > OFFSET_WIDTH) ? POSITION_WIDTH : OFFSET_WIDTH;

    // Configuration and input registers.
    logic [BASE_WIDTH-1:0]     r_cfg_base;
    logic                      r_in_valid;
    logic [CHAR_WIDTH-1:0]     r_in_char;
    logic                      r_in_sos;

    // Parse state.
    t_phase                    r_phase,  n_phase;
    logic                      r_neg,    n_neg;
    logic [VALUE_WIDTH-1:0]    r_acc,    n_acc;
    logic                      r_ovf,    n_ovf;
    logic                      r_dig,    n_dig;
    logic [POSITION_WIDTH-1:0] r_pos,    n_pos;
    logic [BASE_WIDTH-1:0]     r_base,   n_base;

    // Result register.
    logic                      r_out_valid;
    logic [VALUE_WIDTH-1:0]    r_out_value,  n_out_value;
    logic                      r_out_ovf;
    logic                      r_out_any;
    logic [OFFSET_WIDTH-1:0]   r_out_offset, n_out_offset;

    // State as seen by the current character, after a start-of-string clear.
    t_phase                    c_phase;
    logic                      c_neg;
    logic [VALUE_WIDTH-1:0]    c_acc;
    logic                      c_ovf;
    logic                      c_dig;
    logic [POSITION_WIDTH-1:0] c_pos;
    logic [BASE_WIDTH-1:0]     c_base;

    // Decode controls.
    logic [BASE_WIDTH-1:0]     w_eff_base;
    logic                      w_check;
    logic                      w_zero_digit;
    logic [DIGIT_WIDTH-1:0]    w_digit;
    logic                      w_is_digit;
    logic                      w_emit;
    logic                      w_fire;
    logic                      w_out_free;
    logic                      w_cfg_hex_ok;
    logic                      w_is_x;
    logic [SUM_WIDTH-1:0]      w_sum;
    logic [EXT_WIDTH-1:0]      w_pos_ext;

    // Handshake: process the registered character when the result slot is free.
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_fire       = r_in_valid && w_out_free;
    assign i_char.ready = !r_in_valid || w_fire;
    assign i_cfg.ready  = 1'b1;

    // Effective state for this character.
    assign c_phase = r_in_sos ? PH_SKIP : r_phase;
    assign c_neg   = r_in_sos ? 1'b0 : r_neg;
    assign c_acc   = r_in_sos ? '0 : r_acc;
    assign c_ovf   = r_in_sos ? 1'b0 : r_ovf;
    assign c_dig   = r_in_sos ? 1'b0 : r_dig;
    assign c_pos   = r_in_sos ? '0 : r_pos;
    assign c_base  = r_in_sos ? BASE_RESET : r_base;

    assign w_cfg_hex_ok = (r_cfg_base == BASE_AUTO) || (r_cfg_base == BASE_HEX);
    assign w_is_x       = (r_in_char == CHAR_LOWER_X) || (r_in_char == CHAR_UPPER_X);
    assign w_digit      = digit_of(r_in_char);
    assign w_is_digit   = (w_digit != NO_DIGIT) && (w_digit < w_eff_base);

    // Next phase, sign and base selection.
    always_comb begin
        n_phase      = c_phase;
        n_neg        = c_neg;
        n_base       = c_base;
        w_eff_base   = c_base;
        w_check      = 1'b0;
        w_zero_digit = 1'b0;
        unique case (c_phase)
            PH_SKIP, PH_SIGNED: begin
                if (c_phase == PH_SKIP && is_space(r_in_char)) begin
                    n_phase = c_phase;
                end else if (c_phase == PH_SKIP && r_in_char == CHAR_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_SIGNED;
                end else if (c_phase == PH_SKIP && r_in_char == CHAR_PLUS) begin
                    n_phase = PH_SIGNED;
                end else if (r_in_char == CHAR_ZERO && w_cfg_hex_ok) begin
                    n_phase = PH_ZERO;
                end else begin
                    w_eff_base = (r_cfg_base == BASE_AUTO) ? BASE_DECIMAL : r_cfg_base;
                    n_base     = w_eff_base;
                    n_phase    = PH_DIGITS;
                    w_check    = 1'b1;
                end
            end
            PH_ZERO: begin
                if (w_is_x) begin
                    n_base  = BASE_HEX;
                    n_phase = PH_DIGITS;
                end else begin
                    // The held zero counts as a digit.
                    w_eff_base   = (r_cfg_base == BASE_AUTO) ? BASE_OCTAL : r_cfg_base;
                    n_base       = w_eff_base;
                    n_phase      = PH_DIGITS;
                    w_zero_digit = 1'b1;
                    w_check      = 1'b1;
                end
            end
            PH_DIGITS: begin
                w_check = 1'b1;
            end
            default: begin
                n_phase = c_phase;
            end
        endcase
        if (w_check && !w_is_digit) begin
            n_phase = PH_DONE;
        end
    end

    // Accumulator, flags and result fields.
    always_comb begin
        w_sum        = SUM_WIDTH'(c_acc) * SUM_WIDTH'(w_eff_base) + SUM_WIDTH'(w_digit);
        n_acc        = c_acc;
        n_ovf        = c_ovf;
        n_dig        = c_dig || w_zero_digit;
        n_pos        = (c_pos != {POSITION_WIDTH{1'b1}}) ? c_pos + 1'b1 : c_pos;
        w_emit       = w_check && !w_is_digit;
        if (w_check && w_is_digit) begin
            n_dig = 1'b1;
            if (!c_ovf) begin
                if (|w_sum[SUM_WIDTH-1:VALUE_WIDTH]) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = w_sum[VALUE_WIDTH-1:0];
                end
            end
        end
        // Result on the stop character.
        if (c_ovf) begin
            n_out_value = '1;
        end else if (c_neg) begin
            n_out_value = '0 - c_acc;
        end else begin
            n_out_value = c_acc;
        end
        w_pos_ext = EXT_WIDTH'(c_pos);
        if (!n_dig) begin
            n_out_offset = '0;
        end else if (w_pos_ext > EXT_WIDTH'(OFFSET_MAX)) begin
            n_out_offset = OFFSET_MAX;
        end else begin
            n_out_offset = w_pos_ext[OFFSET_WIDTH-1:0];
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base <= BASE_RESET;
        end else if (i_cfg.valid) begin
            r_cfg_base <= i_cfg.number_base;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_code;
            r_in_sos  <= i_char.start_of_string;
        end
    end

    // Parse state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_dig   <= 1'b0;
            r_pos   <= '0;
            r_base  <= BASE_RESET;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_dig   <= n_dig;
            r_pos   <= n_pos;
            r_base  <= n_base;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out_value  <= n_out_value;
            r_out_ovf    <= c_ovf;
            r_out_any    <= n_dig;
            r_out_offset <= n_out_offset;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.value      = RESULT_WIDTH'(r_out_value);
    assign o_result.overflowed = r_out_ovf;
    assign o_result.any_digits = r_out_any;
    assign o_result.end_offset = r_out_offset;

    // An overflowed result is all ones.
    a_ovf_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> (r_out_value == {VALUE_WIDTH{1'b1}}))
        else $error("overflowed result is not all ones");

    // A result without digits is zero at offset zero.
    a_no_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_any) |-> (r_out_value == '0 && r_out_offset == '0 && !r_out_ovf))
        else $error("result without digits is not empty");

    // A produced result leaves the parser finished.
    a_done_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_emit) |=> (r_phase == PH_DONE && r_out_valid))
        else $error("parser not finished after a result");

    // Overflow is only possible after a digit.
    a_ovf_dig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_dig)
        else $error("overflow flagged without a digit");

    // The latched base is never zero while digits are taken.
    a_base_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIGITS) |-> (r_base != BASE_AUTO))
        else $error("zero base in digit phase");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the streaming string to integer parser.
module tb;
    import stip_pkg::*;

    localparam int RANDOM_ITEMS  = 1500;
    localparam int SETTLE_CYCLES = 6;

    // Radix settings used beside the ones the package names.
    localparam logic [BASE_WIDTH-1:0] BASE_UNARY = 6'd1;
    localparam logic [BASE_WIDTH-1:0] BASE_TOP   = 6'd36;
    localparam logic [BASE_WIDTH-1:0] BASE_FULL  = 6'd63;

    // Extra character codes for stimulus.
    localparam logic [CHAR_WIDTH-1:0] CHAR_NUL  = 8'h00;
    localparam logic [CHAR_WIDTH-1:0] CHAR_SEMI = 8'h3B;

    typedef struct packed {
        logic [63:0]             value;
        logic                    overflowed;
        logic                    any_digits;
        logic [OFFSET_WIDTH-1:0] end_offset;
    } t_number;

    logic i_clk;
    logic i_rst_n;

    stip_char_if   chr();
    stip_cfg_if    cfg();
    stip_result_if res();

    string_to_integer_parser u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (chr),
        .i_cfg    (cfg),
        .o_result (res)
    );

    // Shadow copy of the parser state.
    logic [BASE_WIDTH-1:0]   radix_setting;
    logic [BASE_WIDTH-1:0]   radix_in_use;
    t_phase                  scan_phase;
    logic                    minus_seen;
    logic [63:0]             total;
    logic                    total_overflow;
    logic                    digit_taken;
    logic [OFFSET_WIDTH-1:0] char_index;

    t_number pending_numbers[$];
    int      fault_count;
    bit      steady;
    bit      start_pending;
    int      items_sent;

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Value of a character as a digit, 63 when it is none.
    function automatic int unsigned char_value(input logic [CHAR_WIDTH-1:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return 32'(c - CHAR_ZERO);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return 32'(c - CHAR_UPPER_A) + 10;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return 32'(c - CHAR_LOWER_A) + 10;
        return 32'(NO_DIGIT);
    endfunction

    function automatic bit is_blank(input logic [CHAR_WIDTH-1:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic void clear_number();
        scan_phase     = PH_SKIP;
        minus_seen     = 1'b0;
        total          = '0;
        total_overflow = 1'b0;
        digit_taken    = 1'b0;
        char_index     = '0;
        radix_in_use   = BASE_DECIMAL;
    endfunction

    // Exact multiply-add; a carry out of 64 bits marks overflow for good.
    function automatic void add_digit(input int unsigned d);
        logic [69:0] wide;
        if (total_overflow) return;
        wide = 70'(total) * 70'(radix_in_use) + 70'(d);
        if (wide[69:64] != '0) begin
            total_overflow = 1'b1;
        end else begin
            total = wide[63:0];
        end
        digit_taken = 1'b1;
    endfunction

    // Returns 1 when the character ends the number.
    function automatic bit take_digit(input logic [CHAR_WIDTH-1:0] c);
        int unsigned d;
        d = char_value(c);
        if (d == 32'(NO_DIGIT) || d >= 32'(radix_in_use)) return 1'b1;
        add_digit(d);
        return 1'b0;
    endfunction

    // Advances the shadow state by one accepted character.
    function automatic void parse_char(input logic [CHAR_WIDTH-1:0] c, input logic sos);
        logic [OFFSET_WIDTH-1:0] here;
        bit                      stop;
        t_number                 num;
        stop = 1'b0;
        if (sos) clear_number();
        here = char_index;
        if (char_index != OFFSET_MAX) char_index++;
        case (scan_phase)
            PH_SKIP, PH_SIGNED: begin
                if (scan_phase == PH_SKIP && is_blank(c)) begin
                end else if (scan_phase == PH_SKIP && c == CHAR_MINUS) begin
                    minus_seen = 1'b1;
                    scan_phase = PH_SIGNED;
                end else if (scan_phase == PH_SKIP && c == CHAR_PLUS) begin
                    scan_phase = PH_SIGNED;
                end else if (c == CHAR_ZERO &&
                             (radix_setting == BASE_AUTO || radix_setting == BASE_HEX)) begin
                    scan_phase = PH_ZERO;
                end else begin
                    radix_in_use = (radix_setting == BASE_AUTO) ? BASE_DECIMAL : radix_setting;
                    scan_phase   = PH_DIGITS;
                    stop         = take_digit(c);
                end
            end
            PH_ZERO: begin
                scan_phase = PH_DIGITS;
                if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
                    radix_in_use = BASE_HEX;
                end else begin
                    radix_in_use = (radix_setting == BASE_AUTO) ? BASE_OCTAL : radix_setting;
                    add_digit(0);
                    stop = take_digit(c);
                end
            end
            PH_DIGITS: begin
                stop = take_digit(c);
            end
            default: begin
            end
        endcase
        if (stop) begin
            num.value      = total_overflow ? '1 : (minus_seen ? -total : total);
            num.overflowed = total_overflow;
            num.any_digits = digit_taken;
            num.end_offset = digit_taken ? here : '0;
            pending_numbers.push_back(num);
            scan_phase = PH_DONE;
        end
    endfunction

    // Result receiver with random stalls.
    initial begin
        res.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res.ready <= steady || ($urandom_range(0, 99) >= 17);
        end
    end

    // Compare every result transaction with the oldest expected number.
    always @(posedge i_clk) begin : check_results
        t_number want;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_numbers.size() == 0) begin
                $error("unexpected result: value %h", res.value);
                fault_count++;
            end else begin
                want = pending_numbers.pop_front();
                if (res.value !== want.value) begin
                    $error("value: expected %h, got %h", want.value, res.value);
                    fault_count++;
                end
                if (res.overflowed !== want.overflowed) begin
                    $error("overflowed: expected %b, got %b", want.overflowed, res.overflowed);
                    fault_count++;
                end
                if (res.any_digits !== want.any_digits) begin
                    $error("any_digits: expected %b, got %b", want.any_digits, res.any_digits);
                    fault_count++;
                end
                if (res.end_offset !== want.end_offset) begin
                    $error("end_offset: expected %0d, got %0d", want.end_offset,
                           res.end_offset);
                    fault_count++;
                end
            end
        end
    end

    // Sends one character; valid stays high into the next call unless it idles.
    task automatic send_char(input logic [CHAR_WIDTH-1:0] c, input logic sos);
        if (!steady && $urandom_range(0, 99) < 17) begin
            chr.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        chr.valid           <= 1'b1;
        chr.char_code       <= c;
        chr.start_of_string <= sos;
        @(posedge i_clk);
        while (!chr.ready) @(posedge i_clk);
        parse_char(c, sos);
        items_sent++;
    endtask

    // Sends a character, marking it as a string start if one is pending.
    task automatic emit(input logic [CHAR_WIDTH-1:0] c);
        send_char(c, start_pending);
        start_pending = 1'b0;
    endtask

    task automatic emit_text(input string s, input bit sos);
        start_pending = sos;
        for (int i = 0; i < s.len(); i++) emit(s[i]);
    endtask

    // Waits until every expected number has come and the parser is quiet.
    task automatic settle();
        chr.valid <= 1'b0;
        while (pending_numbers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [BASE_WIDTH-1:0] b);
        settle();
        cfg.valid       <= 1'b1;
        cfg.number_base <= b;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        radix_setting = b;
        cfg.valid <= 1'b0;
    endtask

    // The stream after reset counts as a string even without a start mark.
    task automatic test_reset_stream();
        emit_text("7", 1'b0);
        emit(CHAR_NUL);
    endtask

    // White space, a sign, and characters after the result that must be ignored.
    task automatic test_sign_and_blank();
        emit_text("\t-9+z", 1'b1);
        emit_text("--5.", 1'b1);
    endtask

    // Automatic base: hex prefix with no digits, hex, octal, octal stop.
    task automatic test_auto_base();
        write_base(BASE_AUTO);
        emit_text("0xg", 1'b1);
        emit_text("0X1F;", 1'b1);
        emit_text("017", 1'b1);
        emit(CHAR_NUL);
        emit_text("08", 1'b1);
    endtask

    // Smallest and largest radix settings.
    task automatic test_base_extremes();
        write_base(BASE_UNARY);
        emit_text("001", 1'b1);
        write_base(BASE_FULL);
        emit_text("Zz.", 1'b1);
    endtask

    // A base write before the base is latched takes effect, one after does not.
    task automatic test_late_base_write();
        write_base(BASE_DECIMAL);
        emit_text(" +", 1'b1);
        write_base(BASE_HEX);
        emit_text("ff;", 1'b0);
        write_base(BASE_DECIMAL);
        emit_text("1", 1'b1);
        write_base(BASE_OCTAL);
        emit_text("9;", 1'b0);
    endtask

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input int unsigned v);
        if (v < 10) return CHAR_ZERO + CHAR_WIDTH'(v);
        return ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_WIDTH'(v - 10);
    endfunction

    // One well-formed number with random content and a random stop character.
    task automatic send_random_number();
        int unsigned gen_base;
        int unsigned len;
        int unsigned roll;
        start_pending = 1'b1;
        repeat ($urandom_range(0, 2)) begin
            emit($urandom_range(0, 1) ? CHAR_SPACE : 8'($urandom_range(9, 13)));
        end
        case ($urandom_range(0, 3))
            0:       emit(CHAR_MINUS);
            1:       emit(CHAR_PLUS);
            default: ;
        endcase
        gen_base = 32'(radix_setting);
        if ((radix_setting == BASE_AUTO || radix_setting == BASE_HEX) &&
            $urandom_range(0, 2) == 0) begin
            emit(CHAR_ZERO);
            emit($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
            gen_base = 32'(BASE_HEX);
        end else if (radix_setting == BASE_AUTO && $urandom_range(0, 2) == 0) begin
            emit(CHAR_ZERO);
            gen_base = 32'(BASE_OCTAL);
        end else if (radix_setting == BASE_AUTO) begin
            gen_base = 32'(BASE_DECIMAL);
        end
        if (gen_base > 32'(BASE_TOP)) gen_base = 32'(BASE_TOP);
        // Runs of the top digit can push the accumulator past 64 bits.
        roll = $urandom_range(0, 99);
        if (roll < 10) len = $urandom_range(14, 24);
        else if (roll < 25) len = $urandom_range(5, 22);
        else len = $urandom_range(0, 4);
        repeat (len) begin
            emit(digit_char(roll < 10 ? gen_base - 1 : $urandom_range(0, gen_base - 1)));
        end
        case ($urandom_range(0, 3))
            0:       emit(CHAR_NUL);
            1:       emit(CHAR_SPACE);
            2:       emit(CHAR_SEMI);
            default: emit(8'($urandom_range(0, 255)));
        endcase
        repeat ($urandom_range(0, 2)) emit(8'($urandom_range(0, 255)));
    endtask

    task automatic test_random();
        int target;
        int k;
        logic [BASE_WIDTH-1:0] b;
        target = items_sent + RANDOM_ITEMS;
        k      = 0;
        while (items_sent < target) begin
            steady = (k >= 30 && k < 70);
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 7))
                    0:       b = BASE_AUTO;
                    1:       b = BASE_HEX;
                    2:       b = BASE_OCTAL;
                    3:       b = BASE_DECIMAL;
                    4:       b = BASE_UNARY;
                    5:       b = BASE_TOP;
                    6:       b = BASE_FULL;
                    default: b = BASE_WIDTH'($urandom_range(0, 63));
                endcase
                write_base(b);
            end
            if ($urandom_range(0, 9) == 0) begin
                // Noise: random bytes with random start marks.
                repeat ($urandom_range(1, 6)) begin
                    send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end else begin
                send_random_number();
            end
            k++;
        end
        steady = 1'b0;
    endtask

    // Test sequence.
    initial begin
        fault_count         = 0;
        items_sent          = 0;
        steady              = 1'b0;
        start_pending       = 1'b0;
        chr.valid           = 1'b0;
        chr.char_code       = '0;
        chr.start_of_string = 1'b0;
        cfg.valid           = 1'b0;
        cfg.number_base     = '0;
        i_rst_n             = 1'b0;
        radix_setting       = BASE_RESET;
        clear_number();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_stream();
        test_sign_and_blank();
        test_auto_base();
        test_base_extremes();
        test_late_base_write();
        test_random();
        settle();

        if (fault_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
